[src/radial_vignette_pixel_scaler_defines.svh]
// assertion macros for the radial vignette pixel scaler
`ifndef RADIAL_VIGNETTE_PIXEL_SCALER_DEFINES_SVH
`define RADIAL_VIGNETTE_PIXEL_SCALER_DEFINES_SVH

`ifndef ASSERT_OFF
// consequent checked in the same cycle as the antecedent
`define RVPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("rvps assertion failed");
// consequent checked in the cycle after the antecedent
`define RVPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("rvps assertion failed");
`else
`define RVPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RVPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/rvps_pkg.sv]
// shared widths, register indexes and payload types of the vignette scaler
package rvps_pkg;

    localparam int COORD_BITS   = 14;
    localparam int CHANNEL_BITS = 24;

    // configuration port
    localparam int CFG_DATA_BITS = 17;
    localparam int REG_IDX_BITS  = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_STRENGTH     = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_ASPECT_BLEND = 2'd3;

    localparam int SIZE_BITS  = 15;
    localparam int STR_BITS   = 16;
    localparam int BLEND_BITS = 17;
    localparam logic [SIZE_BITS-1:0]  SIZE_MAX_PIX = 15'd16384;
    localparam logic [BLEND_BITS-1:0] BLEND_ONE    = 17'd65536;

    localparam logic [SIZE_BITS-1:0]  FRAME_WIDTH_RST  = 15'd1920;
    localparam logic [SIZE_BITS-1:0]  FRAME_HEIGHT_RST = 15'd1080;
    localparam logic [STR_BITS-1:0]   STRENGTH_RST     = 16'd4096;
    localparam logic [BLEND_BITS-1:0] ASPECT_BLEND_RST = 17'd0;

    // |2p - size|
    localparam int DIFF_BITS = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;

    // axis divider: (d << 32) / span, span below 2^31
    localparam int AX_REM_BITS = 31;
    localparam int AX_QUO_BITS = DIFF_BITS + 16;
    localparam int AX_NUM_BITS = DIFF_BITS + 32;
    localparam int AXIS_BITS   = 31;
    localparam logic [AXIS_BITS-1:0] AXIS_CAP = {AXIS_BITS{1'b1}};

    // falloff math
    localparam int SQ_BITS   = 2 * AXIS_BITS;
    localparam int R2_BITS   = SQ_BITS + 1 - 16;
    localparam int S2_BITS   = 2 * STR_BITS;
    localparam int L2_BITS   = 25;
    localparam logic [L2_BITS-1:0] L2_CAP = 25'h100_0000;
    localparam logic [L2_BITS-1:0] Q_ONE  = 25'h001_0000;
    localparam int FALLOFF_STAGES = 5;

    // factor divider: 2^48 / q^2
    localparam int F_REM_BITS = 50;
    localparam int F_QUO_BITS = 17;
    localparam logic [F_REM_BITS-1:0] F_REM_INIT = F_REM_BITS'({1'b1, 31'b0});

    typedef struct packed {
        logic [COORD_BITS-1:0]   pixel_x;
        logic [COORD_BITS-1:0]   pixel_y;
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
        logic [CHANNEL_BITS-1:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic [CHANNEL_BITS-1:0] alpha_out;
    } pix_out_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
    } chan_t;

endpackage

[src/radial_vignette_pixel_scaler.sv]
// radial vignette pixel scaler: top level with config registers and pipeline
// a request is taken every clock; busy stays low and the receiver cannot stall
// the result strobe follows the request through the input stage, 31-stage
// axis divider, 5 falloff stages, 17-stage factor divider and channel multiply
// throughput one pixel per clock, set by the bit-per-stage dividers
// reset clears config registers to defaults and all valid bits; no clearing pass
`include "radial_vignette_pixel_scaler_defines.svh"

module radial_vignette_pixel_scaler
    import rvps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  pix_in_t                  pixel,
    input  logic                     wr_en,
    input  logic [REG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output logic                     done,
    output pix_out_t                 result
);

    localparam int SIDE_DEPTH = AX_QUO_BITS + FALLOFF_STAGES + F_QUO_BITS;
    localparam int LATENCY    = SIDE_DEPTH + 2;
    localparam int PROD_BITS  = CHANNEL_BITS + F_QUO_BITS;

    // configuration registers
    logic [SIZE_BITS-1:0]  frame_width_reg;
    logic [SIZE_BITS-1:0]  frame_height_reg;
    logic [STR_BITS-1:0]   strength_reg;
    logic [BLEND_BITS-1:0] aspect_blend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            strength_reg     <= STRENGTH_RST;
            aspect_blend_reg <= ASPECT_BLEND_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= wr_data[SIZE_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= wr_data[SIZE_BITS-1:0];
                REG_STRENGTH:     strength_reg     <= wr_data[STR_BITS-1:0];
                REG_ASPECT_BLEND: aspect_blend_reg <= wr_data[BLEND_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // clamped frame size and blend; zero size acts as one
    logic [SIZE_BITS-1:0]  w_cl;
    logic [SIZE_BITS-1:0]  h_cl;
    logic [BLEND_BITS-1:0] b_cl;

    always_comb
    begin
        priority if (frame_width_reg == '0)
            w_cl = SIZE_BITS'(1);
        else if (frame_width_reg > SIZE_MAX_PIX)
            w_cl = SIZE_MAX_PIX;
        else
            w_cl = frame_width_reg;

        priority if (frame_height_reg == '0)
            h_cl = SIZE_BITS'(1);
        else if (frame_height_reg > SIZE_MAX_PIX)
            h_cl = SIZE_MAX_PIX;
        else
            h_cl = frame_height_reg;

        b_cl = (aspect_blend_reg > BLEND_ONE) ? BLEND_ONE : aspect_blend_reg;
    end

    // vignette width in Q.16, registered; read by the divider in the cycle after
    // a request; the user must change config only while idle, not enforced here
    logic                    w_ge_h;
    logic [SIZE_BITS-1:0]    size_gap;
    logic [31:0]             blend_prod;
    logic [AX_REM_BITS-1:0]  vh_span;
    logic [AX_REM_BITS-1:0]  vw_next;
    logic [AX_REM_BITS-1:0]  vw_reg;

    assign w_ge_h     = (w_cl >= h_cl);
    assign size_gap   = w_ge_h ? (w_cl - h_cl) : (h_cl - w_cl);
    assign blend_prod = b_cl * size_gap;
    assign vh_span    = {h_cl, 16'b0};
    assign vw_next    = w_ge_h ? (vh_span + blend_prod[AX_REM_BITS-1:0])
                               : (vh_span - blend_prod[AX_REM_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        vw_reg <= vw_next;
    end

    // request acceptance
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input stage: distance of 2p from the frame size on each axis
    logic [COORD_BITS:0]  two_x;
    logic [COORD_BITS:0]  two_y;
    logic [DIFF_BITS-1:0] ex;
    logic [DIFF_BITS-1:0] ey;
    logic [DIFF_BITS-1:0] ew;
    logic [DIFF_BITS-1:0] eh;
    logic [DIFF_BITS-1:0] dx_next;
    logic [DIFF_BITS-1:0] dy_next;
    logic [DIFF_BITS-1:0] dx_reg;
    logic [DIFF_BITS-1:0] dy_reg;
    logic                 a_valid_reg;
    chan_t                a_chan_reg;

    assign two_x   = {pixel.pixel_x, 1'b0};
    assign two_y   = {pixel.pixel_y, 1'b0};
    assign ex      = DIFF_BITS'(two_x);
    assign ey      = DIFF_BITS'(two_y);
    assign ew      = DIFF_BITS'(w_cl);
    assign eh      = DIFF_BITS'(h_cl);
    assign dx_next = (ex >= ew) ? (ex - ew) : (ew - ex);
    assign dy_next = (ey >= eh) ? (ey - eh) : (eh - ey);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg           <= dx_next;
        dy_reg           <= dy_next;
        a_chan_reg.red   <= pixel.red_in;
        a_chan_reg.green <= pixel.green_in;
        a_chan_reg.blue  <= pixel.blue_in;
        a_chan_reg.alpha <= pixel.alpha_in;
    end

    // axis dividers on d * 2^32
    logic [AX_NUM_BITS-1:0] num_x;
    logic [AX_NUM_BITS-1:0] num_y;
    logic [AX_QUO_BITS-1:0] quo_x;
    logic [AX_QUO_BITS-1:0] quo_y;

    assign num_x = {dx_reg, 32'b0};
    assign num_y = {dy_reg, 32'b0};

    rvps_div_pipe #(
        .REM_BITS (AX_REM_BITS),
        .QUO_BITS (AX_QUO_BITS)
    ) u_div_x (
        .clk    (clk),
        .rem_in (AX_REM_BITS'(num_x[AX_NUM_BITS-1:AX_QUO_BITS])),
        .num_lo (num_x[AX_QUO_BITS-1:0]),
        .den_in (vw_reg),
        .quo    (quo_x)
    );

    rvps_div_pipe #(
        .REM_BITS (AX_REM_BITS),
        .QUO_BITS (AX_QUO_BITS)
    ) u_div_y (
        .clk    (clk),
        .rem_in (AX_REM_BITS'(num_y[AX_NUM_BITS-1:AX_QUO_BITS])),
        .num_lo (num_y[AX_QUO_BITS-1:0]),
        .den_in (vh_span),
        .quo    (quo_y)
    );

    // radius, strength and squared denominator
    logic [F_REM_BITS-1:0] q2;

    rvps_falloff u_falloff (
        .clk      (clk),
        .quo_x    (quo_x),
        .quo_y    (quo_y),
        .strength (strength_reg),
        .q2       (q2)
    );

    // falloff factor 2^48 / q2, at most 1.0 in Q1.16
    logic [F_QUO_BITS-1:0] factor;

    rvps_div_pipe #(
        .REM_BITS (F_REM_BITS),
        .QUO_BITS (F_QUO_BITS)
    ) u_div_f (
        .clk    (clk),
        .rem_in (F_REM_INIT),
        .num_lo ('0),
        .den_in (q2),
        .quo    (factor)
    );

    // channels ride alongside the math
    logic                   side_valid;
    logic [$bits(chan_t)-1:0] side_bits;
    chan_t                  side_chan;

    rvps_delay #(
        .DEPTH (SIDE_DEPTH),
        .WIDTH ($bits(chan_t))
    ) u_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_data   (a_chan_reg),
        .out_valid (side_valid),
        .out_data  (side_bits)
    );

    assign side_chan = chan_t'(side_bits);

    // output stage: scale colour, pass alpha
    logic                    g_valid_reg;
    logic [PROD_BITS-1:0]    g_red_reg;
    logic [PROD_BITS-1:0]    g_green_reg;
    logic [PROD_BITS-1:0]    g_blue_reg;
    logic [CHANNEL_BITS-1:0] g_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else
        begin
            g_valid_reg <= side_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        g_red_reg   <= side_chan.red * factor;
        g_green_reg <= side_chan.green * factor;
        g_blue_reg  <= side_chan.blue * factor;
        g_alpha_reg <= side_chan.alpha;
    end

    // truncate back to Q8.16
    always_comb
    begin
        result.red_out   = g_red_reg[CHANNEL_BITS+15:16];
        result.green_out = g_green_reg[CHANNEL_BITS+15:16];
        result.blue_out  = g_blue_reg[CHANNEL_BITS+15:16];
        result.alpha_out = g_alpha_reg;
    end

    assign done = g_valid_reg;

    // every request yields its result a fixed time later
    `RVPS_ASSERT_SAME(a_req_to_done, clk, rst_n, accept, ##LATENCY done)
    // no result without a request at the matching edge
    `RVPS_ASSERT_SAME(a_done_from_req, clk, rst_n, done, $past(accept, LATENCY))
    // alpha comes through untouched
    `RVPS_ASSERT_SAME(a_alpha_pass, clk, rst_n, done,
        (result.alpha_out == $past(pixel.alpha_in, LATENCY)))
    // falloff never brightens the red channel
    `RVPS_ASSERT_SAME(a_red_dim, clk, rst_n, done,
        (result.red_out <= $past(pixel.red_in, LATENCY)))

endmodule

[src/rvps_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage
module rvps_div_pipe
    import rvps_pkg::*;
#(
    parameter int REM_BITS = 31,
    parameter int QUO_BITS = 31
)
(
    input  logic                clk,
    input  logic [REM_BITS-1:0] rem_in,
    input  logic [QUO_BITS-1:0] num_lo,
    input  logic [REM_BITS-1:0] den_in,
    output logic [QUO_BITS-1:0] quo
);

    logic [REM_BITS-1:0] rem_reg [QUO_BITS];
    logic [REM_BITS-1:0] den_reg [QUO_BITS];
    logic [QUO_BITS-1:0] lo_reg  [QUO_BITS];
    logic [QUO_BITS-1:0] q_reg   [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_stage
        logic [REM_BITS-1:0] rem_cur;
        logic [REM_BITS-1:0] den_cur;
        logic [QUO_BITS-1:0] lo_cur;
        logic [QUO_BITS-1:0] q_cur;
        logic [REM_BITS:0]   trial;
        logic [REM_BITS:0]   diff;
        logic [REM_BITS-1:0] rem_next;
        logic [QUO_BITS-1:0] q_next;

        if (k == 0)
        begin : g_first
            assign rem_cur = rem_in;
            assign den_cur = den_in;
            assign lo_cur  = num_lo;
            assign q_cur   = '0;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign lo_cur  = lo_reg[k-1];
            assign q_cur   = q_reg[k-1];
        end

        // msb of the difference set means the trial fell short of the divisor
        assign trial    = {rem_cur, lo_cur[QUO_BITS-1]};
        assign diff     = trial - {1'b0, den_cur};
        assign rem_next = diff[REM_BITS] ? trial[REM_BITS-1:0] : diff[REM_BITS-1:0];
        assign q_next   = {q_cur[QUO_BITS-2:0], ~diff[REM_BITS]};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            den_reg[k] <= den_cur;
            lo_reg[k]  <= lo_cur << 1;
            q_reg[k]   <= q_next;
        end
    end

    assign quo = q_reg[QUO_BITS-1];

endmodule

[src/rvps_delay.sv]
// delay line for valid and side data
module rvps_delay
    import rvps_pkg::*;
#(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [WIDTH-1:0] data_reg [DEPTH];

    assign valid_next = {valid_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int k = 1; k < DEPTH; k++)
        begin
            data_reg[k] <= data_reg[k-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

[src/rvps_falloff.sv]
// squared radius, strength scaling and squared denominator of the falloff
module rvps_falloff
    import rvps_pkg::*;
(
    input  logic                   clk,
    input  logic [AX_QUO_BITS-1:0] quo_x,
    input  logic [AX_QUO_BITS-1:0] quo_y,
    input  logic [STR_BITS-1:0]    strength,
    output logic [F_REM_BITS-1:0]  q2
);

    logic [AXIS_BITS-1:0] cx;
    logic [AXIS_BITS-1:0] cy;
    logic [SQ_BITS-1:0]   sqx_reg;
    logic [SQ_BITS-1:0]   sqy_reg;
    logic [SQ_BITS:0]     sq_sum;
    logic [R2_BITS-1:0]   r2_reg;
    logic [S2_BITS-1:0]   s2_reg;
    logic [S2_BITS+22:0]  ph_reg;
    logic [S2_BITS+23:0]  pl_reg;
    logic [S2_BITS+23:0]  l2_sum;
    logic [L2_BITS-1:0]   l2_reg;
    logic [L2_BITS-1:0]   l2_next;
    logic [L2_BITS-1:0]   q_val;
    logic [F_REM_BITS-1:0] q2_reg;

    // saturate the normalised coordinates
    assign cx = ((quo_x >> AXIS_BITS) != '0) ? AXIS_CAP : quo_x[AXIS_BITS-1:0];
    assign cy = ((quo_y >> AXIS_BITS) != '0) ? AXIS_CAP : quo_y[AXIS_BITS-1:0];

    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // r2 * s2 in two partial products, upper half weighted by 2^24
    assign l2_sum  = {1'b0, ph_reg} + {24'b0, pl_reg[S2_BITS+23:24]};
    assign l2_next = (l2_sum[S2_BITS+23:24] != '0) ? L2_CAP : {1'b0, l2_sum[23:0]};

    assign q_val = Q_ONE + l2_reg;

    always_ff @(posedge clk)
    begin
        s2_reg  <= strength * strength;
        sqx_reg <= cx * cx;
        sqy_reg <= cy * cy;
        r2_reg  <= sq_sum[SQ_BITS:16];
        ph_reg  <= r2_reg[R2_BITS-1:24] * s2_reg;
        pl_reg  <= r2_reg[23:0] * s2_reg;
        l2_reg  <= l2_next;
        q2_reg  <= q_val * q_val;
    end

    assign q2 = q2_reg;

endmodule

[verif/tb_radial_vignette_pixel_scaler.sv]
// self-checking testbench for the radial vignette pixel scaler
`timescale 1ns / 1ps

module tb_radial_vignette_pixel_scaler;
    import rvps_pkg::*;

    // depth of the pipeline from request to result strobe
    localparam int PIPE_LATENCY = 55;
    localparam int CYCLE_LIMIT  = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    pix_in_t                  pixel;
    logic                     wr_en;
    logic [REG_IDX_BITS-1:0]  wr_index;
    logic [CFG_DATA_BITS-1:0] wr_data;
    logic                     done;
    pix_out_t                 result;

    // shadow copy of the configuration registers
    logic [SIZE_BITS-1:0]  sh_width;
    logic [SIZE_BITS-1:0]  sh_height;
    logic [STR_BITS-1:0]   sh_strength;
    logic [BLEND_BITS-1:0] sh_blend;

    pix_out_t scaled_pixels[$];
    int       error_count;
    longint   cycle_count;

    radial_vignette_pixel_scaler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel    (pixel),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .done     (done),
        .result   (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_radial_vignette_pixel_scaler failed");
            $finish;
        end
    end

    // size registers act as one when zero and cap at the largest frame
    function automatic logic [63:0] sat_size(input logic [SIZE_BITS-1:0] v);
        if (v == 0)
            return 64'd1;
        if (v > SIZE_MAX_PIX)
            return 64'(SIZE_MAX_PIX);
        return 64'(v);
    endfunction

    // normalised distance from centre along one axis, Q.16, capped
    function automatic logic [63:0] axis_dist(input logic [63:0] p, input logic [63:0] sz,
                                              input logic [63:0] span);
        logic [63:0] twice;
        logic [63:0] d;
        logic [63:0] v;
        twice = p << 1;
        d = (twice >= sz) ? twice - sz : sz - twice;
        v = (d << 32) / span;
        return (v > 64'(AXIS_CAP)) ? 64'(AXIS_CAP) : v;
    endfunction

    // cos4 style attenuation factor, Q1.16 in 0..65536
    function automatic logic [63:0] vignette_gain(input logic [63:0] px, input logic [63:0] py);
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] b;
        logic [63:0] vw;
        logic [63:0] cx;
        logic [63:0] cy;
        logic [63:0] r2;
        logic [63:0] s2;
        logic [63:0] l2;
        logic [63:0] q;
        w = sat_size(sh_width);
        h = sat_size(sh_height);
        b = (sh_blend > BLEND_ONE) ? 64'(BLEND_ONE) : 64'(sh_blend);
        if (w >= h)
            vw = (h << 16) + b * (w - h);
        else
            vw = (h << 16) - b * (h - w);
        cx = axis_dist(px, w, vw);
        cy = axis_dist(py, h, h << 16);
        r2 = (cx * cx + cy * cy) >> 16;
        s2 = 64'(sh_strength) * 64'(sh_strength);
        if (s2 == 0)
            l2 = 0;
        else if (r2 > ((64'd1 << 48) - 1) / s2)
            l2 = 64'(L2_CAP);
        else
            l2 = (r2 * s2) >> 24;
        if (l2 > 64'(L2_CAP))
            l2 = 64'(L2_CAP);
        q = 64'd65536 + l2;
        return (64'd1 << 48) / (q * q);
    endfunction

    function automatic pix_out_t scale_pixel(input pix_in_t p);
        pix_out_t    o;
        logic [63:0] g;
        g = vignette_gain(64'(p.pixel_x), 64'(p.pixel_y));
        o.red_out   = CHANNEL_BITS'((64'(p.red_in) * g) >> 16);
        o.green_out = CHANNEL_BITS'((64'(p.green_in) * g) >> 16);
        o.blue_out  = CHANNEL_BITS'((64'(p.blue_in) * g) >> 16);
        o.alpha_out = p.alpha_in;
        return o;
    endfunction

    // result checker: every strobe must match the oldest prediction
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && done)
        begin
            if (scaled_pixels.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                error_count++;
            end
            else
            begin
                want = scaled_pixels.pop_front();
                if (result.red_out !== want.red_out)
                begin
                    $display("%0t: red exp %h got %h", $time, want.red_out, result.red_out);
                    error_count++;
                end
                if (result.green_out !== want.green_out)
                begin
                    $display("%0t: green exp %h got %h", $time, want.green_out,
                             result.green_out);
                    error_count++;
                end
                if (result.blue_out !== want.blue_out)
                begin
                    $display("%0t: blue exp %h got %h", $time, want.blue_out, result.blue_out);
                    error_count++;
                end
                if (result.alpha_out !== want.alpha_out)
                begin
                    $display("%0t: alpha exp %h got %h", $time, want.alpha_out,
                             result.alpha_out);
                    error_count++;
                end
            end
        end
    end

    // idle gap before a request: mostly none or short, now and then long
    task automatic idle_gap();
        int n;
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            n = 0;
        else if (k < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // send one pixel request; start is held over back-to-back requests
    task automatic send_pixel(input pix_in_t p, input bit with_gaps);
        if (with_gaps)
            idle_gap();
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        scaled_pixels.push_back(scale_pixel(p));
        @(negedge clk);
    endtask

    task automatic stop_requests();
        start <= 1'b0;
    endtask

    // wait for the pipeline to empty before touching registers
    task automatic drain();
        stop_requests();
        while (scaled_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  sh_width    = val[SIZE_BITS-1:0];
            REG_FRAME_HEIGHT: sh_height   = val[SIZE_BITS-1:0];
            REG_STRENGTH:     sh_strength = val[STR_BITS-1:0];
            default:          sh_blend    = val[BLEND_BITS-1:0];
        endcase
    endtask

    task automatic set_config(input int w, input int h, input int s, input int b);
        drain();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
        write_reg(REG_STRENGTH, CFG_DATA_BITS'(s));
        write_reg(REG_ASPECT_BLEND, CFG_DATA_BITS'(b));
    endtask

    function automatic pix_in_t make_pixel(input int x, input int y, input int r,
                                           input int g, input int b, input int a);
        pix_in_t p;
        p.pixel_x  = COORD_BITS'(x);
        p.pixel_y  = COORD_BITS'(y);
        p.red_in   = CHANNEL_BITS'(r);
        p.green_in = CHANNEL_BITS'(g);
        p.blue_in  = CHANNEL_BITS'(b);
        p.alpha_in = CHANNEL_BITS'(a);
        return p;
    endfunction

    function automatic pix_in_t random_pixel(input int w, input int h);
        pix_in_t p;
        p = make_pixel(0, 0, $urandom, $urandom, $urandom, $urandom);
        // mostly inside the frame, sometimes anywhere in coordinate space
        if ($urandom_range(0, 3) != 0)
        begin
            p.pixel_x = COORD_BITS'($urandom_range(0, (w > 1 ? w - 1 : 0) % 16384));
            p.pixel_y = COORD_BITS'($urandom_range(0, (h > 1 ? h - 1 : 0) % 16384));
        end
        else
        begin
            p.pixel_x = COORD_BITS'($urandom);
            p.pixel_y = COORD_BITS'($urandom);
        end
        return p;
    endfunction

    // corners, centre and channel extremes at reset settings
    task automatic test_reset_defaults();
        send_pixel(make_pixel(960, 540, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 0);
        send_pixel(make_pixel(0, 0, 24'hFFFFFF, 24'h800000, 24'h000001, 0), 0);
        send_pixel(make_pixel(1919, 1079, 0, 0, 0, 24'hABCDEF), 0);
        send_pixel(make_pixel(16383, 16383, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1), 0);
        send_pixel(make_pixel(0, 540, 24'h010000, 24'h555555, 24'hAAAAAA, 24'h123456), 0);
    endtask

    // zero sizes, oversize sizes, blend above one, tall frame, zero and max strength
    task automatic test_special_settings();
        set_config(0, 0, 65535, 131071);
        send_pixel(make_pixel(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0F0F0F), 0);
        send_pixel(make_pixel(16383, 1, 24'hFFFFFF, 24'h7FFFFF, 24'h1, 24'hF0F0F0), 0);
        set_config(32767, 32767, 0, 65536);
        send_pixel(make_pixel(0, 16383, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0), 0);
        send_pixel(make_pixel(8192, 8192, 24'h123456, 24'h654321, 24'hFFFFFF, 5), 0);
        set_config(16, 4000, 1, 65536);
        send_pixel(make_pixel(16383, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7), 0);
        send_pixel(make_pixel(8, 2000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 9), 0);
        set_config(1, 16384, 40000, 30000);
        send_pixel(make_pixel(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 3), 0);
        send_pixel(make_pixel(1, 16383, 24'hFFFFFF, 24'h000100, 24'hFFFFFF, 2), 0);
    endtask

    // random pixels over several random settings, gaps on the request side
    task automatic test_random_stream();
        int w;
        int h;
        for (int phase = 0; phase < 10; phase++)
        begin
            w = (phase % 3 == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 4096);
            h = (phase % 3 == 1) ? $urandom_range(0, 32767) : $urandom_range(1, 4096);
            set_config(w, h, $urandom_range(0, 65535) >> $urandom_range(0, 4),
                       $urandom_range(0, 131071) >> $urandom_range(0, 1));
            for (int i = 0; i < 110; i++)
                send_pixel(random_pixel(w, h), (phase % 4) != 0);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        pixel       = '0;
        wr_en       = 1'b0;
        wr_index    = REG_FRAME_WIDTH;
        wr_data     = '0;
        error_count = 0;
        cycle_count = 0;
        sh_width    = FRAME_WIDTH_RST;
        sh_height   = FRAME_HEIGHT_RST;
        sh_strength = STRENGTH_RST;
        sh_blend    = ASPECT_BLEND_RST;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_special_settings();
        test_random_stream();
        drain();

        if (error_count == 0)
            $display("tb_radial_vignette_pixel_scaler passed");
        else
            $display("tb_radial_vignette_pixel_scaler failed");
        $finish;
    end

endmodule
